[rtl/core/pngenc_pkg.sv]
// Package with the shared types, constants and helper functions of the PNG encoder.
package pngenc_pkg;

  localparam logic [12:0] MAX_WIDTH  = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned OUTQ_DEPTH = 4;

  localparam logic [31:0] SIG_HI    = 32'h8950_4E47;
  localparam logic [31:0] SIG_LO    = 32'h0D0A_1A0A;
  localparam logic [31:0] IHDR_TYPE = 32'h4948_4452;
  localparam logic [31:0] IDAT_TYPE = 32'h4944_4154;
  localparam logic [31:0] IEND_TYPE = 32'h4945_4E44;
  localparam logic [31:0] IEND_CRC  = 32'hAE42_6082;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PIX,
    ST_FIN
  } back_state_t;

  typedef struct packed {
    logic        is_pixel;
    logic        row_start;
    logic        last;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [12:0] width;
    logic [12:0] height;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eof;
  } obyte_t;

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0: b = v[31:24];
      2'd1: b = v[23:16];
      2'd2: b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] vmax);
    logic [12:0] r;
    if (v == 13'd0) begin
      r = 13'd1;
    end else if (v > vmax) begin
      r = vmax;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/core/pngenc_front.sv]
// Front end that accepts words, tracks the frame position and classifies each word.
module pngenc_front
  import pngenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [12:0] image_width,
  input  logic [12:0] image_height,
  input  logic        accept,
  input  logic        in_command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        wr_en,
  output cmd_t        wr_data
);

  logic        open_r;
  logic [12:0] col_r;
  logic [12:0] row_r;
  logic [12:0] fw_r;
  logic [12:0] fh_r;
  logic [12:0] col_inc;
  logic [12:0] row_inc;
  logic        row_end;
  logic        frame_end;
  logic [12:0] cw;
  logic [12:0] ch;

  assign cw        = clamp_dim(image_width, MAX_WIDTH);
  assign ch        = clamp_dim(image_height, MAX_HEIGHT);
  assign col_inc   = col_r + 13'd1;
  assign row_inc   = row_r + 13'd1;
  assign row_end   = (col_inc == fw_r);
  assign frame_end = row_end && (row_inc == fh_r);

  always_comb begin
    wr_en             = accept && ((in_command == CMD_START) || open_r);
    wr_data.is_pixel  = (in_command == CMD_PIXEL);
    wr_data.row_start = (col_r == 13'd0);
    wr_data.last      = frame_end;
    wr_data.red       = in_red;
    wr_data.green     = in_green;
    wr_data.blue      = in_blue;
    wr_data.alpha     = in_alpha;
    wr_data.width     = cw;
    wr_data.height    = ch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      col_r  <= '0;
      row_r  <= '0;
      fw_r   <= 13'd1;
      fh_r   <= 13'd1;
    end else if (accept) begin
      if (in_command == CMD_START) begin
        open_r <= 1'b1;
        col_r  <= '0;
        row_r  <= '0;
        fw_r   <= cw;
        fh_r   <= ch;
      end else if (open_r) begin
        col_r <= row_end ? 13'd0 : col_inc;
        if (row_end) begin
          row_r <= row_inc;
        end
        if (frame_end) begin
          open_r <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/core/pngenc_cmdq.sv]
// Short command queue between the front end and the byte sequencer.
module pngenc_cmdq
  import pngenc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_data
);

  localparam int unsigned AW = $clog2(CMDQ_DEPTH);

  cmd_t        mem_r [CMDQ_DEPTH];
  logic [AW-1:0] wptr_r;
  logic [AW-1:0] rptr_r;
  logic [AW:0]   cnt_r;
  logic          do_rd;

  assign full     = (cnt_r == (AW+1)'(CMDQ_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rptr_r];
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= wptr_r + AW'(1);
      end
      if (do_rd) begin
        rptr_r <= rptr_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(do_rd);
    end
  end

endmodule

[rtl/core/pngenc_back.sv]
// Byte sequencer with CRC-32, Adler-32, stored block framing and an output queue.
module pngenc_back
  import pngenc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_data,
  output logic       q_take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_end_of_file
);

  localparam int unsigned OW = $clog2(OUTQ_DEPTH);

  back_state_t st_r, st_nxt;
  cmd_t        cur_r;
  logic [5:0]  idx_r;
  logic [2:0]  hidx_r;
  logic [2:0]  pix_r;
  logic [31:0] crc_r;
  logic [15:0] alo_r;
  logic [15:0] ahi_r;
  logic [15:0] blk_r;
  logic [26:0] raw_left_r;
  logic [26:0] raw_len_r;
  logic [11:0] nblk_r;
  logic [31:0] idat_len_r;

  obyte_t        oq_r [OUTQ_DEPTH];
  logic [OW-1:0] owp_r;
  logic [OW-1:0] orp_r;
  logic [OW:0]   ocnt_r;

  logic        emit;
  logic [7:0]  bt;
  logic        last_b;
  logic        eof_b;
  logic        crc_en;
  logic        crc_init;
  logic        hdr_act;
  logic [15:0] blen;
  logic        bfinal;
  logic        pix_done;
  logic        do_pop;
  logic [31:0] crc_in;
  logic [31:0] crc_new;
  logic [16:0] lo_sum;
  logic [15:0] lo_mod;
  logic [16:0] hi_sum;
  logic [15:0] hi_mod;
  logic [27:0] raw_prod;
  logic [16:0] div_r0;
  logic [16:0] div_r1;
  logic        div_ge;
  logic [11:0] div_q;

  assign emit     = (st_r != ST_IDLE) && (ocnt_r != (OW+1)'(OUTQ_DEPTH));
  assign hdr_act  = (blk_r == 16'd0);
  assign bfinal   = (raw_left_r <= 27'(BLOCK_MAX));
  assign blen     = bfinal ? raw_left_r[15:0] : BLOCK_MAX;
  assign pix_done = (st_r == ST_PIX) && !hdr_act && (pix_r == 3'd4);
  assign q_take   = q_valid && ((st_r == ST_IDLE) || (emit && last_b));

  always_comb begin
    logic [5:0] off;
    off      = '0;
    bt       = '0;
    last_b   = 1'b0;
    eof_b    = 1'b0;
    crc_en   = 1'b0;
    crc_init = 1'b0;
    unique case (st_r)
      ST_START: begin
        last_b = (idx_r == 6'd42);
        if (idx_r < 6'd4) begin
          bt = be_byte(SIG_HI, idx_r[1:0]);
        end else if (idx_r < 6'd8) begin
          bt = be_byte(SIG_LO, idx_r[1:0]);
        end else if (idx_r < 6'd12) begin
          bt = be_byte(32'd13, idx_r[1:0]);
        end else if (idx_r < 6'd16) begin
          bt       = be_byte(IHDR_TYPE, idx_r[1:0]);
          crc_en   = 1'b1;
          crc_init = (idx_r == 6'd12);
        end else if (idx_r < 6'd29) begin
          off    = idx_r - 6'd16;
          crc_en = 1'b1;
          unique case (off)
            6'd2:    bt = {3'd0, cur_r.width[12:8]};
            6'd3:    bt = cur_r.width[7:0];
            6'd6:    bt = {3'd0, cur_r.height[12:8]};
            6'd7:    bt = cur_r.height[7:0];
            6'd8:    bt = 8'd8;
            6'd9:    bt = 8'd6;
            default: bt = 8'd0;
          endcase
        end else if (idx_r < 6'd33) begin
          off = idx_r - 6'd29;
          bt  = be_byte(~crc_r, off[1:0]);
        end else if (idx_r < 6'd37) begin
          off = idx_r - 6'd33;
          bt  = be_byte(idat_len_r, off[1:0]);
        end else if (idx_r < 6'd41) begin
          off      = idx_r - 6'd37;
          bt       = be_byte(IDAT_TYPE, off[1:0]);
          crc_en   = 1'b1;
          crc_init = (idx_r == 6'd37);
        end else begin
          bt     = (idx_r == 6'd41) ? 8'h78 : 8'h01;
          crc_en = 1'b1;
        end
      end
      ST_PIX: begin
        crc_en = 1'b1;
        if (hdr_act) begin
          unique case (hidx_r)
            3'd0:    bt = {7'd0, bfinal};
            3'd1:    bt = blen[7:0];
            3'd2:    bt = blen[15:8];
            3'd3:    bt = ~blen[7:0];
            default: bt = ~blen[15:8];
          endcase
        end else begin
          unique case (pix_r)
            3'd1:    bt = cur_r.red;
            3'd2:    bt = cur_r.green;
            3'd3:    bt = cur_r.blue;
            3'd4:    bt = cur_r.alpha;
            default: bt = 8'd0;
          endcase
          last_b = (pix_r == 3'd4) && !cur_r.last;
        end
      end
      ST_FIN: begin
        last_b = (idx_r == 6'd19);
        eof_b  = last_b;
        if (idx_r < 6'd4) begin
          bt     = be_byte({ahi_r, alo_r}, idx_r[1:0]);
          crc_en = 1'b1;
        end else if (idx_r < 6'd8) begin
          bt = be_byte(~crc_r, idx_r[1:0]);
        end else if (idx_r < 6'd12) begin
          bt = 8'd0;
        end else if (idx_r < 6'd16) begin
          bt = be_byte(IEND_TYPE, idx_r[1:0]);
        end else begin
          bt = be_byte(IEND_CRC, idx_r[1:0]);
        end
      end
      default: begin
        bt = 8'd0;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    if (q_take) begin
      st_nxt = q_data.is_pixel ? ST_PIX : ST_START;
    end else if (emit && last_b) begin
      st_nxt = ST_IDLE;
    end else if (emit && pix_done && cur_r.last) begin
      st_nxt = ST_FIN;
    end
  end

  assign crc_in  = crc_init ? 32'hFFFF_FFFF : crc_r;
  assign crc_new = crc_byte(crc_in, bt);
  assign lo_sum  = {1'b0, alo_r} + {9'd0, bt};
  assign lo_mod  = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
  assign hi_sum  = {1'b0, ahi_r} + {1'b0, lo_mod};
  assign hi_mod  = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

  // Blocks of 65535 bytes: q = raw >> 16 leaves raw mod 65535 as low half plus q.
  assign raw_prod = 28'(cur_r.height) * 28'({cur_r.width, 2'b00} + 15'd1);
  assign div_r0   = {1'b0, raw_len_r[15:0]} + {6'd0, raw_len_r[26:16]};
  assign div_ge   = (div_r0 >= {1'b0, BLOCK_MAX});
  assign div_r1   = div_ge ? (div_r0 - {1'b0, BLOCK_MAX}) : div_r0;
  assign div_q    = {1'b0, raw_len_r[26:16]} + 12'(div_ge) + 12'(div_r1 != 17'd0);

  always_ff @(posedge clk) begin
    raw_len_r  <= raw_prod[26:0];
    nblk_r     <= div_q;
    idat_len_r <= 32'(raw_len_r) + 32'(nblk_r) * 32'd5 + 32'd6;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      idx_r      <= '0;
      hidx_r     <= '0;
      pix_r      <= '0;
      crc_r      <= 32'hFFFF_FFFF;
      alo_r      <= 16'd1;
      ahi_r      <= 16'd0;
      blk_r      <= '0;
      raw_left_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (q_take) begin
        cur_r <= q_data;
        idx_r <= '0;
        pix_r <= q_data.row_start ? 3'd0 : 3'd1;
      end else if (emit) begin
        if (pix_done) begin
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + 6'd1;
        end
        if ((st_r == ST_PIX) && !hdr_act) begin
          pix_r <= pix_r + 3'd1;
        end
      end
      if (emit) begin
        if (crc_en) begin
          crc_r <= crc_new;
        end
        if (st_r == ST_START && last_b) begin
          alo_r      <= 16'd1;
          ahi_r      <= 16'd0;
          blk_r      <= '0;
          hidx_r     <= '0;
          raw_left_r <= raw_len_r;
        end else if (st_r == ST_PIX) begin
          if (hdr_act) begin
            if (hidx_r == 3'd4) begin
              hidx_r <= '0;
              blk_r  <= blen;
            end else begin
              hidx_r <= hidx_r + 3'd1;
            end
          end else begin
            alo_r      <= lo_mod;
            ahi_r      <= hi_mod;
            blk_r      <= blk_r - 16'd1;
            raw_left_r <= raw_left_r - 27'd1;
          end
        end
      end
    end
  end

  assign do_pop          = pop && (ocnt_r != '0);
  assign empty           = (ocnt_r == '0);
  assign out_byte        = oq_r[orp_r].data;
  assign out_last_of_run = oq_r[orp_r].last;
  assign out_end_of_file = oq_r[orp_r].eof;

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_r[owp_r] <= '{data: bt, last: last_b, eof: eof_b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (emit) begin
        owp_r <= owp_r + OW'(1);
      end
      if (do_pop) begin
        orp_r <= orp_r + OW'(1);
      end
      ocnt_r <= ocnt_r + (OW+1)'(emit) - (OW+1)'(do_pop);
    end
  end

endmodule

[rtl/core/png_stored_rgba8_encoder.sv]
// Top level of the uncompressed RGBA8 PNG encoder with its register port.
// Output runs at one byte per cycle while the output queue has room; a start word
// yields 43 bytes, a pixel 4 or 5 bytes plus 5 for each stored block header, and the
// last pixel 20 more bytes. The next word is taken as the last byte of one is emitted,
// and each word passes the command queue and the sequencer before its bytes are queued.
// Synchronous active-low reset clears both queues, the frame state and the sizes to 1.
module png_stored_rgba8_encoder
  import pngenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_command,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_end_of_file,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] width_r;
  logic [12:0] height_r;
  logic        cfg_wr;
  logic        accept;
  logic        wr_en;
  cmd_t        wr_data;
  logic        q_take;
  logic        q_valid;
  cmd_t        q_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {19'd0, height_r} : {19'd0, width_r};
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd1;
      height_r <= 13'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_r <= pwdata[12:0];
      end else begin
        height_r <= pwdata[12:0];
      end
    end
  end

  pngenc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .accept       (accept),
    .in_command   (in_command),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_alpha     (in_alpha),
    .wr_en        (wr_en),
    .wr_data      (wr_data)
  );

  pngenc_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .full     (full),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  pngenc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_take          (q_take),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_end_of_file (out_end_of_file)
  );

  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_end_of_file) |-> out_last_of_run)
    else $error("End of file byte is not the last byte of its word.");

  a_width_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && paddr[2] == REG_WIDTH) |=> (width_r == $past(pwdata[12:0])))
    else $error("Width register did not take the written value.");

  a_take_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid)
    else $error("Sequencer took a word from an empty command queue.");

endmodule
